// ===== design/dxt_texture_block_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Shared property wrappers for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DXT_TEXTURE_BLOCK_DECODER_ASSERT_SVH
`define DXT_TEXTURE_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define DXT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked during reset.
`define DXT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT block decoder package
// Block and palette types, mode codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package dxt_pkg;

	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;
	localparam logic [1:0] MODE_DXT5 = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] color_block;
		logic [63:0] alpha_block;
	} block_t;

	// Decoded palettes plus the per-texel index bits
	typedef struct packed {
		logic [1:0]       mode;
		logic [31:0]      cidx;
		logic [63:0]      abits;
		logic [3:0][31:0] cpal;
		logic [7:0][7:0]  apal;
	} pal_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// floor(x/3) for x <= 765
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = {11'd0, x} * 21'd683;
		return p[18:11];
	endfunction

	// floor(x/5) for x <= 1275
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [24:0] p;
		p = {14'd0, x} * 25'd3277;
		return p[21:14];
	endfunction

	// floor(x/7) for x <= 1785
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [24:0] p;
		p = {14'd0, x} * 25'd2341;
		return p[21:14];
	endfunction

endpackage

// ===== design/dxt_pal.sv =====
// ----------------------------------------------------------------------------
// DXT palette pipeline
// Two register stages: endpoint expansion and weighted sums, then divides.
// ----------------------------------------------------------------------------
module dxt_pal (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	output logic            in_rdy,
	input  dxt_pkg::block_t blk,
	output logic            out_vld,
	input  logic            out_rdy,
	output dxt_pkg::pal_t   pal
);
	import dxt_pkg::*;

	typedef struct packed {
		logic [1:0]        mode;
		logic [31:0]       cidx;
		logic [63:0]       abits;
		logic              punch;
		logic [2:0][7:0]   e0;
		logic [2:0][7:0]   e1;
		logic [2:0][9:0]   cs2;
		logic [2:0][9:0]   cs3;
		logic [2:0][7:0]   chalf;
		logic              agt;
		logic [5:0][10:0]  s7;
		logic [3:0][10:0]  s5;
	} sums_t;

	sums_t       sum_d;
	sums_t       sum_s2;
	pal_t        pal_d;
	pal_t        pal_s3;
	logic        v_s2;
	logic        v_s3;
	logic        rdy_s2;
	logic [15:0] c0;
	logic [15:0] c1;
	logic [7:0]  a0;
	logic [7:0]  a1;
	logic [8:0]  hsum;
	logic [7:0]  a0_s;
	logic [7:0]  a1_s;

	assign rdy_s2  = !v_s3 || out_rdy;
	assign in_rdy  = !v_s2 || rdy_s2;
	assign out_vld = v_s3;
	assign pal     = pal_s3;

	// stage 2: expand endpoints, form weighted sums
	always_comb begin
		c0 = blk.color_block[15:0];
		c1 = blk.color_block[31:16];
		a0 = blk.alpha_block[7:0];
		a1 = blk.alpha_block[15:8];
		hsum = '0;
		sum_d.mode  = blk.mode;
		sum_d.cidx  = blk.color_block[63:32];
		sum_d.abits = blk.alpha_block;
		sum_d.punch = c0 < c1;
		sum_d.agt   = a0 > a1;
		sum_d.e0[0] = widen5(c0[4:0]);
		sum_d.e0[1] = widen6(c0[10:5]);
		sum_d.e0[2] = widen5(c0[15:11]);
		sum_d.e1[0] = widen5(c1[4:0]);
		sum_d.e1[1] = widen6(c1[10:5]);
		sum_d.e1[2] = widen5(c1[15:11]);
		for (int k = 0; k < 3; k++) begin
			sum_d.cs2[k] = {1'b0, sum_d.e0[k], 1'b0} + {2'b00, sum_d.e1[k]};
			sum_d.cs3[k] = {1'b0, sum_d.e1[k], 1'b0} + {2'b00, sum_d.e0[k]};
			hsum = {1'b0, sum_d.e0[k]} + {1'b0, sum_d.e1[k]};
			sum_d.chalf[k] = hsum[8:1];
		end
		for (int i = 2; i < 8; i++) begin
			sum_d.s7[i-2] = 11'(a0 * (8 - i) + a1 * (i - 1));
		end
		for (int i = 2; i < 6; i++) begin
			sum_d.s5[i-2] = 11'(a0 * (6 - i) + a1 * (i - 1));
		end
	end

	// stage 3: divides and palette selection
	always_comb begin
		a0_s = sum_s2.abits[7:0];
		a1_s = sum_s2.abits[15:8];
		pal_d.mode    = sum_s2.mode;
		pal_d.cidx    = sum_s2.cidx;
		pal_d.abits   = sum_s2.abits;
		pal_d.cpal[0] = {8'hff, sum_s2.e0};
		pal_d.cpal[1] = {8'hff, sum_s2.e1};
		if (sum_s2.punch) begin
			pal_d.cpal[2] = {8'hff, sum_s2.chalf};
			pal_d.cpal[3] = 32'h0;
		end else begin
			pal_d.cpal[2] = {8'hff, div3(sum_s2.cs2[2]), div3(sum_s2.cs2[1]),
				div3(sum_s2.cs2[0])};
			pal_d.cpal[3] = {8'hff, div3(sum_s2.cs3[2]), div3(sum_s2.cs3[1]),
				div3(sum_s2.cs3[0])};
		end
		pal_d.apal[0] = a0_s;
		pal_d.apal[1] = a1_s;
		if (sum_s2.agt) begin
			for (int i = 2; i < 8; i++) begin
				pal_d.apal[i] = div7(sum_s2.s7[i-2]);
			end
		end else begin
			for (int i = 2; i < 6; i++) begin
				pal_d.apal[i] = div5(sum_s2.s5[i-2]);
			end
			pal_d.apal[6] = 8'd0;
			pal_d.apal[7] = 8'd255;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_rdy) begin
				v_s2 <= in_vld;
			end
			if (rdy_s2) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			sum_s2 <= sum_d;
		end
		if (rdy_s2 && v_s2) begin
			pal_s3 <= pal_d;
		end
	end

endmodule

// ===== design/dxt_texture_block_decoder.sv =====
// ----------------------------------------------------------------------------
// DXT texture block decoder
// Decodes one DXT1/DXT3/DXT5 4x4 block into sixteen BGRA texels, row-major.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload                         | Unit
//  --------+-----------------------+---------------------------------+---------------
//  input   | in_valid / in_stall   | mode, color_block, alpha_block  | one block
//  output  | out_valid / out_stall | pixel, texel_position, last     | one texel
//
//  Each block leaves as sixteen texels, one per output transfer; out_stall can hold any.
//  A block passes s1, s2, s3 and s4 before its first texel is registered in s5.
//  Reset (arst_n, asynchronous, active low) empties every pipeline stage.
//  A stall at the output holds the texel register and backs up stage by stage;
//  up to three further blocks wait behind the one in s4 before in_stall rises.
//
// Stages:
//   s1  input register
//   s2  endpoint expansion, weighted sums for the interpolants (dxt_pal)
//   s3  constant divides, colour and alpha palettes (dxt_pal)
//   s4  block held while a counter walks its sixteen texels
//   s5  output texel register
// ----------------------------------------------------------------------------
`include "dxt_texture_block_decoder_assert.svh"

module dxt_texture_block_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] color_block,
	input  logic [63:0] alpha_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel,
	output logic [3:0]  texel_position,
	output logic        last
);
	import dxt_pkg::*;

	block_t      blk_s1;
	logic        v_s1;
	logic        pal_rdy;
	logic        pal_vld;
	pal_t        pal_out;
	pal_t        pal_s4;
	logic        v_s4;
	logic [3:0]  cnt_q;
	logic        emit;
	logic        done;
	logic        rdy_s4;
	logic [31:0] px;
	logic [7:0]  abyte;
	logic [7:0]  alpha;
	logic [1:0]  ci;
	logic [2:0]  ai;
	logic [31:0] pixel_s5;
	logic [3:0]  pos_s5;
	logic        last_s5;
	logic        v_s5;

	// s1 frees up whenever the palette pipe takes its block
	assign in_stall = v_s1 && !pal_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			blk_s1 <= '{mode: mode, color_block: color_block, alpha_block: alpha_block};
		end
	end

	dxt_pal u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s1),
		.in_rdy  (pal_rdy),
		.blk     (blk_s1),
		.out_vld (pal_vld),
		.out_rdy (rdy_s4),
		.pal     (pal_out)
	);

	// s4: one texel leaves per cycle whenever the output register can take it.
	// The block is released on its sixteenth texel, so the next one can load
	// in that same cycle with no bubble.
	assign emit   = v_s4 && (!v_s5 || !out_stall);
	assign done   = emit && (cnt_q == 4'd15);
	assign rdy_s4 = !v_s4 || done;

	// texel select: colour index, then alpha by mode
	always_comb begin
		ci    = pal_s4.cidx[{cnt_q, 1'b0} +: 2];
		ai    = pal_s4.abits[6'd16 + 6'(cnt_q) * 6'd3 +: 3];
		abyte = pal_s4.abits[{cnt_q[3:1], 3'b000} +: 8];
		px    = pal_s4.cpal[ci];
		alpha = px[31:24];
		case (pal_s4.mode)
			MODE_DXT3: begin
				// high nibble to the even texel, low nibble to the odd one
				alpha = cnt_q[0] ? {abyte[3:0], 4'h0} : {abyte[7:4], 4'h0};
			end
			MODE_DXT5: begin
				alpha = pal_s4.apal[ai];
			end
			default: begin
				// DXT1 and the unused code keep the palette alpha
				alpha = px[31:24];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			cnt_q <= 4'd0;
			v_s5  <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= pal_vld;
			end
			if (emit) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (emit) begin
				v_s5 <= 1'b1;
			end else if (!out_stall) begin
				v_s5 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && pal_vld) begin
			pal_s4 <= pal_out;
		end
		if (emit) begin
			pixel_s5 <= {alpha, px[23:0]};
			pos_s5   <= cnt_q;
			last_s5  <= cnt_q == 4'd15;
		end
	end

	assign out_valid      = v_s5;
	assign pixel          = pixel_s5;
	assign texel_position = pos_s5;
	assign last           = last_s5;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`DXT_ASSERT_NOW(a_last_pos, clk, arst_n, out_valid, last == (&texel_position), "last flag off")
	`DXT_ASSERT_NOW(a_cnt_held, clk, arst_n, cnt_q != 4'd0, v_s4, "counter mid-block, no block")
	`DXT_ASSERT_NEXT(a_pos_seq, clk, arst_n,
		out_valid && !out_stall && !last,
		!out_valid || texel_position == $past(texel_position) + 4'd1,
		"texel positions out of sequence")

endmodule
